@@ rtl/wfmr_pkg.sv @@
// ----------------------------------------------------------------------------
// wfmr_pkg
// Shared types and constants for the word FIFO with match removal.
// ----------------------------------------------------------------------------
package wfmr_pkg;

    localparam int OUT_WORD_BITS = 32;
    localparam int OUT_CNT_BITS  = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

endpackage

@@ rtl/word_fifo_with_match_removal_core.sv @@
// ----------------------------------------------------------------------------
// word_fifo_with_match_removal_core
// Ring-buffer FIFO of words with push, pop, clear and remove-all-matching.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its single result comes
// back as a one-cycle done strobe and cannot be held off. Push, clear, a pop
// on an empty FIFO and a removal on an empty FIFO return their result in the
// cycle after the beat and the next beat may follow at once. A pop passes
// through S_POP, which waits for the registered read of the word store. A
// removal passes through S_SCAN, where the word store is walked one entry
// per cycle through its single read port while kept words are written back
// in place, compacting towards the head.
module word_fifo_with_match_removal_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] value,
    output logic        done,
    output logic [31:0] read_word,
    output logic [1:0]  status,
    output logic [4:0]  fill_level,
    output logic [4:0]  removed_total
);

    import wfmr_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [OUT_CNT_BITS-1:0] to_cnt(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_BITS-1:0] e;
        e = {{OUT_CNT_BITS{1'b0}}, c};
        return e[OUT_CNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_WORD_BITS-1:0] to_word(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS+OUT_WORD_BITS-1:0] e;
        e = {{OUT_WORD_BITS{1'b0}}, w};
        return e[OUT_WORD_BITS-1:0];
    endfunction

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     kept_reg, kept_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [WORD_BITS-1:0] match_reg, match_next;

    logic                    done_reg, done_next;
    logic [OUT_WORD_BITS-1:0] rword_reg, rword_next;
    status_t                 status_reg, status_next;
    logic [OUT_CNT_BITS-1:0] fill_reg, fill_next;
    logic [OUT_CNT_BITS-1:0] removed_reg, removed_next;

    logic [WORD_BITS+31:0]   value_ext;
    logic [WORD_BITS-1:0]    in_word;

    assign value_ext = {{WORD_BITS{1'b0}}, value};
    assign in_word   = value_ext[WORD_BITS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        kept_next    = kept_reg;
        rem_next     = rem_reg;
        match_next   = match_reg;
        done_next    = 1'b0;
        rword_next   = rword_reg;
        status_next  = status_reg;
        fill_next    = fill_reg;
        removed_next = removed_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        mem_wdata    = in_word;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode_t'(opcode))
                        OP_PUSH:
                        begin
                            done_next    = 1'b1;
                            rword_next   = '0;
                            removed_next = '0;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                fill_next   = to_cnt(count_reg);
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = ptr_add(head_reg, count_reg);
                                mem_wdata   = in_word;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_OK;
                                fill_next   = to_cnt(count_reg + CNT_W'(1));
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next    = 1'b1;
                                rword_next   = '0;
                                status_next  = ST_EMPTY;
                                fill_next    = '0;
                                removed_next = '0;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                state_next = S_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            done_next    = 1'b1;
                            rword_next   = '0;
                            status_next  = ST_OK;
                            fill_next    = '0;
                            removed_next = '0;
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next    = 1'b1;
                                rword_next   = '0;
                                status_next  = ST_OK;
                                fill_next    = '0;
                                removed_next = '0;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                idx_next   = '0;
                                kept_next  = '0;
                                rem_next   = '0;
                                match_next = in_word;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next    = 1'b1;
                rword_next   = to_word(rd_data_reg);
                status_next  = ST_OK;
                head_next    = ptr_add(head_reg, CNT_W'(1));
                count_next   = count_reg - CNT_W'(1);
                fill_next    = to_cnt(count_reg - CNT_W'(1));
                removed_next = '0;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                // kept words are written back in place, never ahead of the read
                if (rd_data_reg != match_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_add(head_reg, kept_reg);
                    mem_wdata = rd_data_reg;
                    kept_next = kept_reg + CNT_W'(1);
                end
                else
                begin
                    rem_next = rem_reg + CNT_W'(1);
                end
                if (idx_reg != count_reg - CNT_W'(1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_add(head_reg, idx_reg + CNT_W'(1));
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    count_next   = kept_next;
                    done_next    = 1'b1;
                    rword_next   = '0;
                    status_next  = ST_OK;
                    fill_next    = to_cnt(kept_next);
                    removed_next = to_cnt(rem_next);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        kept_reg    <= kept_next;
        rem_reg     <= rem_next;
        match_reg   <= match_next;
        rword_reg   <= rword_next;
        status_reg  <= status_next;
        fill_reg    <= fill_next;
        removed_reg <= removed_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign read_word     = rword_reg;
    assign status        = status_reg;
    assign fill_level    = fill_reg;
    assign removed_total = removed_reg;

endmodule
